### rtl/ihfi_pkg.sv
// Shared types, constants and header rewrite functions for the IP header fault injector.
// Used by every module and interface of the block; depends on nothing.
package ihfi_pkg;

  localparam int HEADER_BYTES_DEF = 40;
  localparam int HDR_MAX          = 64;
  localparam int LEN_W            = $clog2(HDR_MAX + 1);
  localparam int BYTE_W           = 8;
  localparam int NIB_W            = 4;
  localparam int MODE_W           = 3;
  localparam int QDEPTH           = 2;
  localparam int QPTR_W           = $clog2(QDEPTH);

  localparam logic [NIB_W-1:0] VER_V4 = 4'h4;
  localparam logic [NIB_W-1:0] VER_V6 = 4'h6;

  localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TTL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PROTO = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COPY  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MCAST = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LEN   = 3'd5;

  localparam logic [LEN_W-1:0] V4_LEN_HI = 7'd2;
  localparam logic [LEN_W-1:0] V4_LEN_LO = 7'd3;
  localparam logic [LEN_W-1:0] V4_TTL    = 7'd8;
  localparam logic [LEN_W-1:0] V4_PROTO  = 7'd9;
  localparam logic [LEN_W-1:0] V4_SA     = 7'd12;
  localparam logic [LEN_W-1:0] V4_DA     = 7'd16;
  localparam logic [LEN_W-1:0] V4_AL     = 7'd4;
  localparam logic [LEN_W-1:0] V6_PLEN_HI = 7'd4;
  localparam logic [LEN_W-1:0] V6_PLEN_LO = 7'd5;
  localparam logic [LEN_W-1:0] V6_NXT    = 7'd6;
  localparam logic [LEN_W-1:0] V6_HOP    = 7'd7;
  localparam logic [LEN_W-1:0] V6_SA     = 7'd8;
  localparam logic [LEN_W-1:0] V6_DA     = 7'd24;
  localparam logic [LEN_W-1:0] V6_AL     = 7'd16;

  localparam logic [BYTE_W-1:0] MCAST_V4_TOP = 8'd239;
  localparam logic [BYTE_W-1:0] ALL_ONES     = 8'hFF;

  typedef struct packed {
    logic              is_hdr;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [NIB_W-1:0]  ver;
    logic [MODE_W-1:0] mode;
    logic              pick;
    logic [NIB_W-1:0]  na;
    logic [NIB_W-1:0]  nb;
  } job_t;

  typedef struct packed {
    logic [LEN_W-1:0] addr;
    logic             copy;
  } src_t;

  // Buffer position that supplies the output byte at position pos.
  function automatic src_t src_map(input logic [NIB_W-1:0] ver, input logic [MODE_W-1:0] mode,
                                   input logic pick, input logic [LEN_W-1:0] pos);
    src_t s;
    logic [LEN_W-1:0] sa, da, al;
    s.addr = pos;
    s.copy = 1'b0;
    if (ver == VER_V4) begin
      sa = V4_SA;
      da = V4_DA;
      al = V4_AL;
    end else begin
      sa = V6_SA;
      da = V6_DA;
      al = V6_AL;
    end
    if (mode == MODE_COPY && (ver == VER_V4 || ver == VER_V6)) begin
      if (!pick && pos >= sa && pos < sa + al) begin
        s.addr = pos + (da - sa);
        s.copy = 1'b1;
      end else if (pick && pos >= da && pos < da + al) begin
        s.addr = pos - (da - sa);
        s.copy = 1'b1;
      end
    end
    return s;
  endfunction

  // Field overrides applied on the way out: fixed values, or the random nibbles for MODE_LEN.
  function automatic logic [BYTE_W-1:0] patch(input logic [NIB_W-1:0] ver,
                                              input logic [MODE_W-1:0] mode,
                                              input logic [LEN_W-1:0] pos,
                                              input logic [NIB_W-1:0] na,
                                              input logic [NIB_W-1:0] nb,
                                              input logic [BYTE_W-1:0] rd);
    logic [BYTE_W-1:0] b;
    b = rd;
    if (ver == VER_V4) begin
      unique case (mode)
        MODE_TTL:   if (pos == V4_TTL) b = '0;
        MODE_PROTO: if (pos == V4_PROTO) b = ALL_ONES;
        MODE_MCAST: begin
          if (pos == V4_SA) b = MCAST_V4_TOP;
          else if (pos > V4_SA && pos < V4_SA + V4_AL) b = ALL_ONES;
        end
        MODE_LEN: begin
          if (pos == V4_LEN_HI) b = '0;
          else if (pos == V4_LEN_LO) b = {{(BYTE_W-NIB_W){1'b0}}, na};
        end
        default: b = rd;
      endcase
    end else if (ver == VER_V6) begin
      unique case (mode)
        MODE_TTL:   if (pos == V6_HOP) b = '0;
        MODE_PROTO: if (pos == V6_NXT) b = ALL_ONES;
        MODE_MCAST: begin
          if (pos == V6_SA) b = ALL_ONES;
          else if (pos > V6_SA && pos < V6_SA + V6_AL) b = '0;
        end
        MODE_LEN: begin
          if (pos == V6_PLEN_HI) b = {{(BYTE_W-NIB_W){1'b0}}, na};
          else if (pos == V6_PLEN_LO) b = {{(BYTE_W-NIB_W){1'b0}}, nb};
        end
        default: b = rd;
      endcase
    end
    return b;
  endfunction

endpackage

### rtl/ihfi_in_if.sv
// Input channel of the IP header fault injector: one packet byte per item.
// Depends on ihfi_pkg.
interface ihfi_in_if import ihfi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              end_of_packet;
  logic              swap_pick;
  logic [NIB_W-1:0]  random_nibble_a;
  logic [NIB_W-1:0]  random_nibble_b;

  modport source(output valid, byte_value, end_of_packet, swap_pick, random_nibble_a,
                 random_nibble_b, input ready);
  modport sink(input valid, byte_value, end_of_packet, swap_pick, random_nibble_a,
               random_nibble_b, output ready);
endinterface

### rtl/ihfi_out_if.sv
// Result channel of the IP header fault injector: one output byte per item.
// Depends on ihfi_pkg.
interface ihfi_out_if import ihfi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source(output valid, out_byte, out_last, input ready);
  modport sink(input valid, out_byte, out_last, output ready);
endinterface

### rtl/ihfi_cfg_if.sv
// Configuration write channel carrying the corrupt_mode register value.
// Depends on ihfi_pkg.
interface ihfi_cfg_if import ihfi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] corrupt_mode;

  modport source(output valid, corrupt_mode, input ready);
  modport sink(input valid, corrupt_mode, output ready);
endinterface

### rtl/ip_header_fault_injector_core.sv
// Header bytes are sent once the item that completes the header has been queued, each
// read from the buffer read port and held before it leaves; payload bytes pass at one
// per cycle through the job queue and output register while the output is not stalled.
// The next packet is held off until the previous header has been flushed.
// Reset (rst_n, synchronous) clears control state and the mode; the buffer is not cleared.
// Depends on ihfi_pkg, the three channel interfaces and all ihfi_* modules.
module ip_header_fault_injector_core import ihfi_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ihfi_in_if.sink     in_ch,
  ihfi_out_if.source  out_ch,
  ihfi_cfg_if.sink    cfg_ch
);

  localparam int ADDR_W = $clog2(HEADER_BYTES);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              push;
  job_t              push_job;
  logic              q_full;
  logic              q_pop;
  job_t              q_job;
  logic              q_empty;
  logic              hdr_done;

  ihfi_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full),
    .hdr_done (hdr_done)
  );

  ihfi_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wjob (push_job),
    .full (q_full),
    .pop  (q_pop),
    .rjob (q_job),
    .empty(q_empty)
  );

  ihfi_ram #(.WIDTH(BYTE_W), .DEPTH(HEADER_BYTES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ihfi_back #(.HEADER_BYTES(HEADER_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_job    (q_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .hdr_done (hdr_done),
    .out_ch   (out_ch)
  );

endmodule

### rtl/ihfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on ihfi_pkg for default sizes.
module ihfi_ram import ihfi_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = HEADER_BYTES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ihfi_fifo.sv
// Short job queue between the front and back parts of the fault injector.
// Depends on ihfi_pkg for job_t and the queue depth.
module ihfi_fifo import ihfi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wjob,
  output logic full,
  input  logic pop,
  output job_t rjob,
  output logic empty
);

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rjob  = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      q_r[wptr_r] <= wjob;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("Job pushed into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("Job popped from an empty queue.");
`endif

endmodule

### rtl/ihfi_front.sv
// Front part: accepts bytes, holds the mode register, stores header bytes and queues jobs.
// Depends on ihfi_pkg and the input and configuration interfaces.
module ihfi_front import ihfi_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int ADDR_W = $clog2(HEADER_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  ihfi_in_if.sink           in_ch,
  ihfi_cfg_if.sink          cfg_ch,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              push,
  output job_t              push_job,
  input  logic              q_full,
  input  logic              hdr_done
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ADDR_W-1:0] count_r, count_nxt;
  logic              passing_r, passing_nxt;
  logic              pend_r, pend_nxt;
  logic [NIB_W-1:0]  ver_r, ver_nxt;
  logic              acc;
  logic [LEN_W-1:0]  len;
  logic              hdr_end;
  logic [NIB_W-1:0]  cur_ver;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full && (passing_r || !pend_r);
  assign acc          = in_ch.valid && in_ch.ready;
  assign len          = LEN_W'(count_r) + LEN_W'(1);
  assign hdr_end      = (len == LEN_W'(HEADER_BYTES)) || in_ch.end_of_packet;
  assign cur_ver      = (count_r == '0) ? in_ch.byte_value[BYTE_W-1 -: NIB_W] : ver_r;

  assign ram_we    = acc && !passing_r;
  assign ram_waddr = count_r;
  assign ram_wdata = in_ch.byte_value;
  assign push      = acc && (passing_r || hdr_end);

  always_comb begin
    push_job.is_hdr = !passing_r;
    push_job.data   = in_ch.byte_value;
    push_job.last   = in_ch.end_of_packet;
    push_job.len    = len;
    push_job.ver    = cur_ver;
    push_job.mode   = mode_r;
    push_job.pick   = in_ch.swap_pick;
    push_job.na     = in_ch.random_nibble_a;
    push_job.nb     = in_ch.random_nibble_b;
  end

  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    passing_nxt = passing_r;
    pend_nxt    = pend_r;
    ver_nxt     = ver_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      mode_nxt = cfg_ch.corrupt_mode;
    end
    if (hdr_done) begin
      pend_nxt = 1'b0;
    end
    if (acc) begin
      if (passing_r) begin
        if (in_ch.end_of_packet) begin
          passing_nxt = 1'b0;
        end
      end else begin
        ver_nxt = cur_ver;
        if (hdr_end) begin
          count_nxt   = '0;
          passing_nxt = !in_ch.end_of_packet;
          pend_nxt    = 1'b1;
        end else begin
          count_nxt = len[ADDR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NONE;
      count_r   <= '0;
      passing_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      count_r   <= count_nxt;
      passing_r <= passing_nxt;
      pend_r    <= pend_nxt;
    end
    ver_r <= ver_nxt;
  end

`ifndef ASSERT_OFF
  a_no_write_in_flush: assert property (@(posedge clk) disable iff (!rst_n) pend_r |-> !ram_we)
    else $error("Header buffer written while a flush is pending.");
`endif

endmodule

### rtl/ihfi_back.sv
// Back part: takes jobs from the queue, reads and rewrites the held header, drives the output.
// Depends on ihfi_pkg and the result interface.
module ihfi_back import ihfi_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int ADDR_W = $clog2(HEADER_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              q_job,
  input  logic              q_empty,
  output logic              q_pop,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output logic              hdr_done,
  ihfi_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_HDR  = 2'b10
  } bstate_t;

  bstate_t           state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic              rv_r, rv_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              slot_free;
  logic              last_pos;
  src_t              src;
  logic [BYTE_W-1:0] rd_eff;
  logic [BYTE_W-1:0] hdr_byte;

  assign slot_free = !ov_r || out_ch.ready;
  assign src       = src_map(job_r.ver, job_r.mode, job_r.pick, pos_r);
  assign ram_raddr = src.addr[ADDR_W-1:0];
  assign rd_eff    = (src.copy && src.addr >= job_r.len) ? '0 : ram_rdata;
  assign hdr_byte  = patch(job_r.ver, job_r.mode, pos_r, job_r.na, job_r.nb, rd_eff);
  assign last_pos  = (pos_r == job_r.len - LEN_W'(1));

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.out_last = ol_r;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    pos_nxt   = pos_r;
    rv_nxt    = rv_r;
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    hdr_done  = 1'b0;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_job.is_hdr) begin
            q_pop     = 1'b1;
            job_nxt   = q_job;
            pos_nxt   = '0;
            rv_nxt    = 1'b0;
            state_nxt = B_HDR;
          end else if (slot_free) begin
            q_pop  = 1'b1;
            ov_nxt = 1'b1;
            ob_nxt = q_job.data;
            ol_nxt = q_job.last;
          end
        end
      end
      B_HDR: begin
        if (rv_r && slot_free) begin
          ov_nxt = 1'b1;
          ob_nxt = hdr_byte;
          ol_nxt = job_r.last && last_pos;
          rv_nxt = 1'b0;
          if (last_pos) begin
            hdr_done  = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            pos_nxt = pos_r + LEN_W'(1);
          end
        end else begin
          rv_nxt = 1'b1;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
    end
    job_r <= job_nxt;
    pos_r <= pos_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_HDR |-> pos_r < job_r.len)
    else $error("Header position ran past the packet length.");
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_done |=> state_r == B_IDLE && ov_r)
    else $error("Header flush finished without returning to idle with the last byte held.");
`endif

endmodule

### tb/sv/ip_header_fault_injector_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ip_header_fault_injector_core: drives packets byte by byte,
// predicts each rewritten header and passed payload byte, and checks every output item.
// Depends on ihfi_pkg, the three ihfi channel interfaces and the core itself.
module ip_header_fault_injector_core_tb;
  import ihfi_pkg::*;

  localparam int HB = HEADER_BYTES_DEF;

  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct {
    logic [BYTE_W-1:0] byte_value;
    logic              eop;
    logic              pick;
    logic [NIB_W-1:0]  na;
    logic [NIB_W-1:0]  nb;
  } pkt_byte_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_byte_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_t;

  logic clk;
  logic rst_n;

  ihfi_in_if  in_ch();
  ihfi_out_if out_ch();
  ihfi_cfg_if cfg_ch();

  ip_header_fault_injector_core #(.HEADER_BYTES(HB)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pkt_byte_t     byte_queue[$];
  out_byte_t     expected_bytes[$];
  idle_profile_t idle_profile;
  int unsigned   bytes_queued;
  int unsigned   bytes_taken;
  int unsigned   mismatches;
  logic          in_taken;

  logic [BYTE_W-1:0] hdr_shadow [HB];
  int unsigned       fill_cnt;
  bit                in_payload;
  logic [MODE_W-1:0] mode_shadow;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void set_hdr(int unsigned hlen, int unsigned pos, logic [BYTE_W-1:0] v);
    if (pos < hlen && pos < HB) hdr_shadow[pos] = v;
  endfunction

  function automatic logic [BYTE_W-1:0] get_hdr(int unsigned hlen, int unsigned pos);
    if (pos < hlen && pos < HB) return hdr_shadow[pos];
    return '0;
  endfunction

  function automatic void copy_field(int unsigned hlen, int unsigned dst, int unsigned src,
                                     int unsigned n);
    logic [BYTE_W-1:0] tmp [16];
    for (int unsigned i = 0; i < n; i++) tmp[i] = get_hdr(hlen, src + i);
    for (int unsigned i = 0; i < n; i++) set_hdr(hlen, dst + i, tmp[i]);
  endfunction

  function automatic void corrupt_header(int unsigned hlen, logic pick,
                                         logic [NIB_W-1:0] na, logic [NIB_W-1:0] nb);
    logic [NIB_W-1:0] ver;
    ver = hdr_shadow[0][7:4];
    if (ver == VER_V4) begin
      case (mode_shadow)
        MODE_TTL:   set_hdr(hlen, V4_TTL, 8'h00);
        MODE_PROTO: set_hdr(hlen, V4_PROTO, ALL_ONES);
        MODE_COPY: begin
          if (!pick) copy_field(hlen, V4_SA, V4_DA, V4_AL);
          else copy_field(hlen, V4_DA, V4_SA, V4_AL);
        end
        MODE_MCAST: begin
          set_hdr(hlen, V4_SA, MCAST_V4_TOP);
          for (int unsigned i = 1; i < V4_AL; i++) set_hdr(hlen, V4_SA + i, ALL_ONES);
        end
        MODE_LEN: begin
          set_hdr(hlen, V4_LEN_HI, 8'h00);
          set_hdr(hlen, V4_LEN_LO, {4'h0, na});
        end
        default: ;
      endcase
    end else if (ver == VER_V6) begin
      case (mode_shadow)
        MODE_TTL:   set_hdr(hlen, V6_HOP, 8'h00);
        MODE_PROTO: set_hdr(hlen, V6_NXT, ALL_ONES);
        MODE_COPY: begin
          if (!pick) copy_field(hlen, V6_SA, V6_DA, V6_AL);
          else copy_field(hlen, V6_DA, V6_SA, V6_AL);
        end
        MODE_MCAST: begin
          set_hdr(hlen, V6_SA, ALL_ONES);
          for (int unsigned i = 1; i < V6_AL; i++) set_hdr(hlen, V6_SA + i, 8'h00);
        end
        MODE_LEN: begin
          set_hdr(hlen, V6_PLEN_HI, {4'h0, na});
          set_hdr(hlen, V6_PLEN_LO, {4'h0, nb});
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void predict_bytes(pkt_byte_t it);
    int unsigned hlen;
    out_byte_t   e;
    if (in_payload) begin
      e.data = it.byte_value;
      e.last = it.eop;
      expected_bytes = {expected_bytes, e};
      if (it.eop) begin
        in_payload = 1'b0;
        fill_cnt = 0;
      end
      return;
    end
    if (fill_cnt < HB) hdr_shadow[fill_cnt] = it.byte_value;
    hlen = fill_cnt + 1;
    if (hlen < HB && !it.eop) begin
      fill_cnt = hlen;
      return;
    end
    corrupt_header(hlen, it.pick, it.na, it.nb);
    for (int unsigned i = 0; i < hlen && i < HB; i++) begin
      e.data = hdr_shadow[i];
      e.last = it.eop && (i + 1 == hlen);
      expected_bytes = {expected_bytes, e};
    end
    fill_cnt = 0;
    in_payload = !it.eop;
  endfunction

  function automatic bit sender_idles();
    case (idle_profile)
      IDLE_SENDER: return $urandom_range(99) < 71;
      IDLE_BOTH:   return $urandom_range(99) < 7;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_profile)
      IDLE_RECEIVER: return $urandom_range(99) < 71;
      IDLE_BOTH:     return $urandom_range(99) < 7;
      default:       return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin
    pkt_byte_t nxt;
    if (!in_ch.valid || in_taken) begin
      if (byte_queue.size() > 0 && !sender_idles()) begin
        nxt = byte_queue.pop_front();
        in_ch.valid           <= 1'b1;
        in_ch.byte_value      <= nxt.byte_value;
        in_ch.end_of_packet   <= nxt.eop;
        in_ch.swap_pick       <= nxt.pick;
        in_ch.random_nibble_a <= nxt.na;
        in_ch.random_nibble_b <= nxt.nb;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= !receiver_stalls();
  end

  always @(posedge clk) begin
    out_byte_t exp_b;
    pkt_byte_t seen;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output item: out_byte %0h out_last %0b", out_ch.out_byte,
               out_ch.out_last);
        mismatches++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_ch.out_byte !== exp_b.data) begin
          $error("out_byte mismatch: expected %0h, actual %0h", exp_b.data, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.out_last !== exp_b.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", exp_b.last, out_ch.out_last);
          mismatches++;
        end
      end
    end
    in_taken <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) begin
      seen.byte_value = in_ch.byte_value;
      seen.eop        = in_ch.end_of_packet;
      seen.pick       = in_ch.swap_pick;
      seen.na         = in_ch.random_nibble_a;
      seen.nb         = in_ch.random_nibble_b;
      predict_bytes(seen);
      bytes_taken++;
    end
  end

  task automatic push_packet(int unsigned total, logic [BYTE_W-1:0] first_byte, logic last_pick);
    pkt_byte_t it;
    for (int unsigned i = 0; i < total; i++) begin
      it.byte_value = (i == 0) ? first_byte : BYTE_W'($urandom_range(255));
      it.eop        = (i == total - 1);
      it.pick       = it.eop ? last_pick : 1'($urandom_range(1));
      it.na         = NIB_W'($urandom_range(15));
      it.nb         = NIB_W'($urandom_range(15));
      byte_queue = {byte_queue, it};
      bytes_queued++;
    end
  endtask

  task automatic push_random_packet();
    int unsigned      r;
    int unsigned      total;
    logic [NIB_W-1:0] ver;
    r   = $urandom_range(99);
    ver = $urandom_range(1) ? VER_V4 : VER_V6;
    if (r < 10) begin
      ver   = NIB_W'($urandom_range(15));
      total = $urandom_range(50, 1);
    end else if (r < 30) begin
      total = $urandom_range(HB - 1, 1);
    end else begin
      total = HB + $urandom_range(8);
    end
    push_packet(total, {ver, 4'($urandom_range(15))}, 1'($urandom_range(1)));
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.corrupt_mode <= m;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    mode_shadow = m;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (bytes_taken != bytes_queued || expected_bytes.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    logic [MODE_W-1:0] phase_modes [8];
    int unsigned       phase_start;
    phase_modes = '{MODE_NONE, MODE_TTL, MODE_PROTO, MODE_COPY, MODE_MCAST, MODE_LEN,
                    MODE_SPARE_6, MODE_SPARE_7};
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.byte_value      = '0;
    in_ch.end_of_packet   = 1'b0;
    in_ch.swap_pick       = 1'b0;
    in_ch.random_nibble_a = '0;
    in_ch.random_nibble_b = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.corrupt_mode   = '0;
    in_taken              = 1'b0;
    idle_profile          = IDLE_NONE;
    bytes_queued          = 0;
    bytes_taken           = 0;
    mismatches            = 0;
    fill_cnt              = 0;
    in_payload            = 1'b0;
    mode_shadow           = MODE_NONE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Short packets: one-byte packets of both extremes, an IPv4 header cut inside the
    // source address, an IPv6 stub, and a packet of another version.
    write_mode(MODE_COPY);
    push_packet(1, 8'h00, 1'b0);
    push_packet(1, 8'hFF, 1'b1);
    push_packet(14, {VER_V4, 4'h5}, 1'b0);
    push_packet(5, {VER_V6, 4'h0}, 1'b1);
    push_packet(3, {4'h7, 4'hF}, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      idle_profile = idle_profile_t'(p % 4);
      write_mode(phase_modes[p]);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 30) push_random_packet();
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
